// ===== sv/arpc_pkg.sv =====
// ============================================================================
// arpc_pkg
// Types, codes and helpers shared by the ARP cache with pending requests.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package arpc_pkg;

  typedef enum logic [1:0] {
    CMD_LOOKUP  = 2'd0,
    CMD_INSERT  = 2'd1,
    CMD_PENDING = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_ANSWER    = 3'd0,
    KIND_ARP_REQ   = 3'd1,
    KIND_RELEASE   = 3'd2,
    KIND_UNREACH   = 3'd3,
    KIND_PEND_FULL = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_E_PRIME,
    ST_E_SCAN,
    ST_S_PRIME,
    ST_S_SCAN,
    ST_FIN,
    ST_DRAIN
  } state_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_MAX_AGE     = 2'd0;
  localparam logic [1:0] REG_RETRY_INT   = 2'd1;
  localparam logic [1:0] REG_MAX_RETRIES = 2'd2;

  localparam logic [7:0] MAX_AGE_RST     = 8'd15;
  localparam logic [7:0] RETRY_INT_RST   = 8'd1;
  localparam logic [7:0] MAX_RETRIES_RST = 8'd5;

  // Results reported per request; further results are dropped.
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = 5;

  typedef struct packed {
    logic [7:0]  age;
    logic [47:0] mac;
    logic [31:0] ip;
  } ent_t;

  typedef struct packed {
    logic [7:0]  packets;
    logic [7:0]  age;
    logic [7:0]  retries;
    logic [3:0]  iface;
    logic [31:0] ip;
  } slot_t;

  typedef struct packed {
    kind_t       kind;
    logic        hit;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [3:0]  iface;
    logic [2:0]  slot;
    logic [7:0]  count;
  } res_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

`default_nettype wire

// ===== sv/arpc_ram.sv =====
// ============================================================================
// arpc_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/arp_cache_with_pending_requests.sv =====
// ============================================================================
// arp_cache_with_pending_requests
// IP-to-MAC cache with a file of pending ARP requests, walked by a sequencer.
// ============================================================================
// Usage: one request on the in_ channel carries a command in in_tuser
// (lookup, insert reply, packet awaiting resolution, one-second tick) and
// the address fields in in_tdata. Results leave on the out_ channel, kind in
// out_tuser, with out_tlast on the final result of a request. Requests that
// cause no result (an insert with nothing pending, a quiet tick, a repeat
// packet) produce nothing on out_. Configuration writes on cfg_ are always
// accepted and are meant for idle periods.
// Timing: the walk reads cache entries, then pending slots, from two
// RAMs, one per cycle, though a full output can stall the slot walk; a
// lookup reads only entries and a waiting packet only slots, and a slot
// that reports twice on a tick is read again.
// in_tready is high only between requests.
// Reset clears all valid bits and loads the default register values; no
// clearing pass is needed. When out_tready is low, one result waits in the
// output register and one more is held; further results stall the walk.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module arp_cache_with_pending_requests #(
  parameter int CACHE_ENTRIES = 32,
  parameter int PENDING_SLOTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // ip_addr[31:0], mac_addr[79:32], iface_id[83:80], zero [87:84]
  input  wire logic [87:0] in_tdata,
  // cmd[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // hit[0], result_ip[32:1], found_mac[80:33], out_iface[84:81],
  // pending_slot[87:85], packet_count[95:88]
  output logic [95:0]      out_tdata,
  // kind[2:0]
  output logic [2:0]       out_tuser,
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int EIW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int SIW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;

  arpc_pkg::state_t state_r, state_nxt;
  arpc_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [31:0]      ip_r, ip_nxt;
  logic [47:0]      mac_r, mac_nxt;
  logic [3:0]       iface_r, iface_nxt;
  logic [EIW-1:0]   eidx_r, eidx_nxt;
  logic [SIW-1:0]   sidx_r, sidx_nxt;
  logic [CACHE_ENTRIES-1:0] ev_r, ev_nxt;
  logic [PENDING_SLOTS-1:0] sv_r, sv_nxt;
  logic [7:0]       max_age_r, retry_int_r, max_ret_r;

  logic             hit_r, hit_nxt;
  logic [47:0]      hmac_r, hmac_nxt;
  logic             placed_r, placed_nxt;
  logic             match_r, match_nxt;
  logic [SIW-1:0]   match_idx_r, match_idx_nxt;
  logic [7:0]       match_ret_r, match_ret_nxt;
  logic [7:0]       match_pkt_r, match_pkt_nxt;
  logic             free_v_r, free_v_nxt;
  logic [SIW-1:0]   free_idx_r, free_idx_nxt;
  logic             phase2_r, phase2_nxt;

  logic [arpc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  arpc_pkg::res_t   held_r, held_nxt;
  logic             held_v_r, held_v_nxt;
  arpc_pkg::res_t   out_r, out_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_v_r, out_v_nxt;

  // RAM ports
  logic             ent_we;
  arpc_pkg::ent_t   ent_wdata, ent_rd;
  logic [EIW-1:0]   ent_raddr;
  logic             slot_we;
  logic [SIW-1:0]   slot_waddr, slot_raddr;
  arpc_pkg::slot_t  slot_wdata, slot_rd;

  // Walk datapath
  logic             e_last, s_last, ev_cur, sv_cur;
  logic [7:0]       e_age, s_age1, s_ret1;
  logic             e_expire, s_send, s_unr, s_ipm, s_ifm;
  logic             s_adv;
  logic             emit_req, emit_room, suppress, out_free;
  arpc_pkg::res_t   emit_res;

  arpc_ram #(.WIDTH($bits(arpc_pkg::ent_t)), .DEPTH(CACHE_ENTRIES)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (eidx_r),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rd)
  );

  arpc_ram #(.WIDTH($bits(arpc_pkg::slot_t)), .DEPTH(PENDING_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rd)
  );

  assign e_last   = (eidx_r == EIW'(CACHE_ENTRIES - 1));
  assign s_last   = (sidx_r == SIW'(PENDING_SLOTS - 1));
  assign ev_cur   = ev_r[eidx_r];
  assign sv_cur   = sv_r[sidx_r];
  assign e_age    = arpc_pkg::sat_inc(ent_rd.age);
  assign e_expire = (e_age > max_age_r);
  assign s_age1   = arpc_pkg::sat_inc(slot_rd.age);
  assign s_send   = (s_age1 > retry_int_r);
  assign s_ret1   = s_send ? arpc_pkg::sat_inc(slot_rd.retries) : slot_rd.retries;
  assign s_unr    = (s_ret1 >= max_ret_r);
  assign s_ipm    = (slot_rd.ip == ip_r);
  assign s_ifm    = (slot_rd.iface == iface_r);

  assign suppress  = (cnt_r >= arpc_pkg::CNT_W'(arpc_pkg::MAX_RESULTS));
  assign out_free  = !out_v_r || out_tready;
  // A new result fits when the held stage is empty or can move out, or when it will be suppressed.
  assign emit_room = suppress || !held_v_r || out_free;

  assign in_tready  = (state_r == arpc_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {out_r.count, out_r.slot, out_r.iface, out_r.mac, out_r.ip, out_r.hit};

  // Sequencer: next state, walk control and RAM writes.
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    ip_nxt        = ip_r;
    mac_nxt       = mac_r;
    iface_nxt     = iface_r;
    eidx_nxt      = eidx_r;
    sidx_nxt      = sidx_r;
    ev_nxt        = ev_r;
    sv_nxt        = sv_r;
    hit_nxt       = hit_r;
    hmac_nxt      = hmac_r;
    placed_nxt    = placed_r;
    match_nxt     = match_r;
    match_idx_nxt = match_idx_r;
    match_ret_nxt = match_ret_r;
    match_pkt_nxt = match_pkt_r;
    free_v_nxt    = free_v_r;
    free_idx_nxt  = free_idx_r;
    phase2_nxt    = phase2_r;
    ent_we        = 1'b0;
    ent_wdata     = '0;
    ent_raddr     = '0;
    slot_we       = 1'b0;
    slot_waddr    = sidx_r;
    slot_wdata    = slot_rd;
    slot_raddr    = '0;
    s_adv         = 1'b1;
    emit_req      = 1'b0;
    emit_res      = '0;

    case (state_r)
      arpc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt    = arpc_pkg::cmd_t'(in_tuser);
          ip_nxt     = in_tdata[31:0];
          mac_nxt    = in_tdata[79:32];
          iface_nxt  = in_tdata[83:80];
          eidx_nxt   = '0;
          sidx_nxt   = '0;
          hit_nxt    = 1'b0;
          placed_nxt = 1'b0;
          match_nxt  = 1'b0;
          free_v_nxt = 1'b0;
          phase2_nxt = 1'b0;
          state_nxt  = (arpc_pkg::cmd_t'(in_tuser) == arpc_pkg::CMD_PENDING) ?
                       arpc_pkg::ST_S_PRIME : arpc_pkg::ST_E_PRIME;
        end
      end

      arpc_pkg::ST_E_PRIME: begin
        state_nxt = arpc_pkg::ST_E_SCAN;
      end

      arpc_pkg::ST_E_SCAN: begin
        ent_raddr = eidx_r + EIW'(1);
        case (cmd_r)
          arpc_pkg::CMD_LOOKUP: begin
            if (ev_cur && ent_rd.ip == ip_r && !hit_r) begin
              hit_nxt  = 1'b1;
              hmac_nxt = ent_rd.mac;
            end
          end
          arpc_pkg::CMD_INSERT: begin
            if (!ev_cur && !placed_r) begin
              ent_we         = 1'b1;
              ent_wdata.age  = 8'd0;
              ent_wdata.mac  = mac_r;
              ent_wdata.ip   = ip_r;
              ev_nxt[eidx_r] = 1'b1;
              placed_nxt     = 1'b1;
            end
          end
          arpc_pkg::CMD_TICK: begin
            if (ev_cur) begin
              ent_we        = 1'b1;
              ent_wdata.age = e_age;
              ent_wdata.mac = ent_rd.mac;
              ent_wdata.ip  = ent_rd.ip;
              if (e_expire) begin
                ev_nxt[eidx_r] = 1'b0;
              end
            end
          end
          default: ;
        endcase
        eidx_nxt = eidx_r + EIW'(1);
        if (e_last) begin
          state_nxt = (cmd_r == arpc_pkg::CMD_LOOKUP) ? arpc_pkg::ST_FIN : arpc_pkg::ST_S_PRIME;
        end
      end

      arpc_pkg::ST_S_PRIME: begin
        state_nxt = arpc_pkg::ST_S_SCAN;
      end

      arpc_pkg::ST_S_SCAN: begin
        case (cmd_r)
          arpc_pkg::CMD_INSERT: begin
            if (sv_cur && s_ipm) begin
              emit_req       = 1'b1;
              emit_res.kind  = arpc_pkg::KIND_RELEASE;
              emit_res.ip    = ip_r;
              emit_res.mac   = mac_r;
              emit_res.iface = slot_rd.iface;
              emit_res.slot  = 3'(sidx_r);
              emit_res.count = slot_rd.packets;
              if (emit_room) begin
                sv_nxt[sidx_r] = 1'b0;
              end else begin
                s_adv = 1'b0;
              end
            end
          end
          arpc_pkg::CMD_PENDING: begin
            if (sv_cur && s_ipm && s_ifm && !match_r) begin
              match_nxt     = 1'b1;
              match_idx_nxt = sidx_r;
              match_ret_nxt = slot_rd.retries;
              match_pkt_nxt = slot_rd.packets;
            end
            if (!sv_cur && !free_v_r) begin
              free_v_nxt   = 1'b1;
              free_idx_nxt = sidx_r;
            end
          end
          arpc_pkg::CMD_TICK: begin
            if (sv_cur) begin
              emit_res.ip    = slot_rd.ip;
              emit_res.iface = slot_rd.iface;
              emit_res.slot  = 3'(sidx_r);
              emit_res.count = slot_rd.packets;
              if (!phase2_r && s_send) begin
                emit_req      = 1'b1;
                emit_res.kind = arpc_pkg::KIND_ARP_REQ;
                if (!emit_room) begin
                  s_adv = 1'b0;
                end else if (s_unr) begin
                  // The slot also gives up; report that on a second pass over the same slot.
                  phase2_nxt = 1'b1;
                  s_adv      = 1'b0;
                end else begin
                  slot_we            = 1'b1;
                  slot_wdata.retries = s_ret1;
                  slot_wdata.age     = 8'd0;
                end
              end else if (s_unr) begin
                emit_req      = 1'b1;
                emit_res.kind = arpc_pkg::KIND_UNREACH;
                if (emit_room) begin
                  sv_nxt[sidx_r] = 1'b0;
                  phase2_nxt     = 1'b0;
                end else begin
                  s_adv = 1'b0;
                end
              end else begin
                slot_we        = 1'b1;
                slot_wdata.age = s_age1;
              end
            end
          end
          default: ;
        endcase
        slot_raddr = s_adv ? sidx_r + SIW'(1) : sidx_r;
        if (s_adv) begin
          sidx_nxt = sidx_r + SIW'(1);
          if (s_last) begin
            state_nxt = (cmd_r == arpc_pkg::CMD_PENDING) ? arpc_pkg::ST_FIN : arpc_pkg::ST_DRAIN;
          end
        end
      end

      arpc_pkg::ST_FIN: begin
        emit_res.ip    = ip_r;
        emit_res.iface = iface_r;
        case (cmd_r)
          arpc_pkg::CMD_LOOKUP: begin
            emit_req       = 1'b1;
            emit_res.kind  = arpc_pkg::KIND_ANSWER;
            emit_res.hit   = hit_r;
            emit_res.mac   = hit_r ? hmac_r : 48'd0;
            emit_res.iface = 4'd0;
            if (emit_room) begin
              state_nxt = arpc_pkg::ST_DRAIN;
            end
          end
          arpc_pkg::CMD_PENDING: begin
            if (match_r) begin
              slot_we            = 1'b1;
              slot_waddr         = match_idx_r;
              slot_wdata.ip      = ip_r;
              slot_wdata.iface   = iface_r;
              slot_wdata.retries = arpc_pkg::sat_inc(match_ret_r);
              slot_wdata.age     = 8'd0;
              slot_wdata.packets = arpc_pkg::sat_inc(match_pkt_r);
              state_nxt          = arpc_pkg::ST_DRAIN;
            end else if (free_v_r) begin
              emit_req       = 1'b1;
              emit_res.kind  = arpc_pkg::KIND_ARP_REQ;
              emit_res.slot  = 3'(free_idx_r);
              emit_res.count = 8'd1;
              if (emit_room) begin
                slot_we              = 1'b1;
                slot_waddr           = free_idx_r;
                slot_wdata.ip        = ip_r;
                slot_wdata.iface     = iface_r;
                slot_wdata.retries   = 8'd0;
                slot_wdata.age       = 8'd0;
                slot_wdata.packets   = 8'd1;
                sv_nxt[free_idx_r]   = 1'b1;
                state_nxt            = arpc_pkg::ST_DRAIN;
              end
            end else begin
              emit_req      = 1'b1;
              emit_res.kind = arpc_pkg::KIND_PEND_FULL;
              if (emit_room) begin
                state_nxt = arpc_pkg::ST_DRAIN;
              end
            end
          end
          default: begin
            state_nxt = arpc_pkg::ST_DRAIN;
          end
        endcase
      end

      arpc_pkg::ST_DRAIN: begin
        if (!held_v_r || out_free) begin
          state_nxt = arpc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = arpc_pkg::ST_IDLE;
      end
    endcase
  end

  // Result path: the newest result is held until the next one or the end of
  // the request decides whether it carries tlast.
  always_comb begin
    held_nxt     = held_r;
    held_v_nxt   = held_v_r;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    out_v_nxt    = out_v_r && !out_tready;
    cnt_nxt      = cnt_r;

    if (state_r == arpc_pkg::ST_IDLE && in_tvalid) begin
      cnt_nxt = '0;
    end
    if (emit_req && emit_room && !suppress) begin
      if (held_v_r) begin
        out_nxt      = held_r;
        out_last_nxt = 1'b0;
        out_v_nxt    = 1'b1;
      end
      held_nxt   = emit_res;
      held_v_nxt = 1'b1;
      cnt_nxt    = cnt_r + arpc_pkg::CNT_W'(1);
    end
    if (state_r == arpc_pkg::ST_DRAIN && held_v_r && out_free) begin
      out_nxt      = held_r;
      out_last_nxt = 1'b1;
      out_v_nxt    = 1'b1;
      held_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arpc_pkg::ST_IDLE;
      ev_r        <= '0;
      sv_r        <= '0;
      held_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
      cnt_r       <= '0;
      max_age_r   <= arpc_pkg::MAX_AGE_RST;
      retry_int_r <= arpc_pkg::RETRY_INT_RST;
      max_ret_r   <= arpc_pkg::MAX_RETRIES_RST;
    end else begin
      state_r  <= state_nxt;
      ev_r     <= ev_nxt;
      sv_r     <= sv_nxt;
      held_v_r <= held_v_nxt;
      out_v_r  <= out_v_nxt;
      cnt_r    <= cnt_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          arpc_pkg::REG_MAX_AGE:     max_age_r   <= cfg_data;
          arpc_pkg::REG_RETRY_INT:   retry_int_r <= cfg_data;
          arpc_pkg::REG_MAX_RETRIES: max_ret_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    ip_r        <= ip_nxt;
    mac_r       <= mac_nxt;
    iface_r     <= iface_nxt;
    eidx_r      <= eidx_nxt;
    sidx_r      <= sidx_nxt;
    hit_r       <= hit_nxt;
    hmac_r      <= hmac_nxt;
    placed_r    <= placed_nxt;
    match_r     <= match_nxt;
    match_idx_r <= match_idx_nxt;
    match_ret_r <= match_ret_nxt;
    match_pkt_r <= match_pkt_nxt;
    free_v_r    <= free_v_nxt;
    free_idx_r  <= free_idx_nxt;
    phase2_r    <= phase2_nxt;
    held_r      <= held_nxt;
    out_r       <= out_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Between requests nothing may be left in the held stage.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == arpc_pkg::ST_IDLE) |-> !held_v_r)
    else $error("held result left over at idle");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= arpc_pkg::CNT_W'(arpc_pkg::MAX_RESULTS))
    else $error("result count beyond limit");

  // A result enters the held stage only as a counted emission.
  a_held_counted: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(held_v_r) |-> (cnt_r != $past(cnt_r)))
    else $error("held result appeared without being counted");

  a_fin_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == arpc_pkg::ST_FIN) |->
      (cmd_r == arpc_pkg::CMD_LOOKUP || cmd_r == arpc_pkg::CMD_PENDING))
    else $error("final step reached by wrong command");

endmodule

`default_nettype wire
